// ===== rtl/core/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared state type and state codes for the trial division primality test core
// ----------------------------------------------------------------------------
package tdpt_pkg;

   typedef logic [1:0] state_type;

   localparam state_type ST_IDLE  = 2'd0;
   localparam state_type ST_DIV   = 2'd1;
   localparam state_type ST_CHECK = 2'd2;
   localparam state_type ST_FIN   = 2'd3;

endpackage

// ===== rtl/core/trial_division_primality_test_core.sv =====
// 0, 1, 2 and even values are settled without dividing; otherwise k odd trial divisors
// are tried in turn from three (k up to about 2^(VALUE_WIDTH/2 - 1)), and
// each divisor costs one bit-serial restoring division
// throughput: one value at a time, the next transfer is taken once the result is staged
// reset: synchronous, active high, clears control state only
// ----------------------------------------------------------------------------
// trial_division_primality_test_core
// tests one unsigned value for primality by trial division with odd divisors,
// computing value / d and value % d one quotient bit per cycle
// ----------------------------------------------------------------------------
module trial_division_primality_test_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_prime
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   tdpt_pkg::state_type    state_ff, state_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] shr_ff, shr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;

   logic [VALUE_WIDTH:0]   rem_shift;
   logic                   fits;

   // one restoring division step: bring in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, shr_ff[VALUE_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};

   assign req_ready    = (state_ff == tdpt_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      shr_in       = shr_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               val_in = req_value;
               div_in = VALUE_WIDTH'(3);
               rem_in = '0;
               shr_in = req_value;
               cnt_in = CNT_W'(VALUE_WIDTH - 1);
               if (req_value[VALUE_WIDTH-1:1] == '0) begin
                  res_in   = 1'b0;
                  state_in = tdpt_pkg::ST_FIN;
               end else if (req_value == VALUE_WIDTH'(2)) begin
                  res_in   = 1'b1;
                  state_in = tdpt_pkg::ST_FIN;
               end else if (!req_value[0]) begin
                  res_in   = 1'b0;
                  state_in = tdpt_pkg::ST_FIN;
               end else begin
                  state_in = tdpt_pkg::ST_DIV;
               end
            end
         end
         tdpt_pkg::ST_DIV: begin
            // quotient bits shift in from the bottom as dividend bits leave the top
            rem_in = fits ? VALUE_WIDTH'(rem_shift - {1'b0, div_ff})
                          : rem_shift[VALUE_WIDTH-1:0];
            shr_in = {shr_ff[VALUE_WIDTH-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = tdpt_pkg::ST_CHECK;
            end
         end
         tdpt_pkg::ST_CHECK: begin
            // shr_ff now holds value / d, rem_ff holds value % d
            if (div_ff > shr_ff) begin
               res_in   = 1'b1;
               state_in = tdpt_pkg::ST_FIN;
            end else if (rem_ff == '0) begin
               res_in   = 1'b0;
               state_in = tdpt_pkg::ST_FIN;
            end else begin
               div_in   = div_ff + VALUE_WIDTH'(2);
               rem_in   = '0;
               shr_in   = val_ff;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
               state_in = tdpt_pkg::ST_DIV;
            end
         end
         tdpt_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               state_in     = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      shr_ff       <= shr_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // divisor is always odd and at least three while dividing
   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == tdpt_pkg::ST_DIV |-> div_ff[0] && div_ff >= VALUE_WIDTH'(3))
      else $error("trial divisor not odd or below three");

   // partial remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == tdpt_pkg::ST_DIV |-> rem_ff < div_ff)
      else $error("partial remainder out of range");

   // a request transfer always starts work
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != tdpt_pkg::ST_IDLE)
      else $error("request transfer did not start a test");

   // a result is only staged from the finish state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == tdpt_pkg::ST_FIN)
      else $error("result staged outside finish state");

endmodule
